@@ src/bsc_pkg.sv @@
// Shared types, constants and microcode for the barometric compensation unit.
// No dependencies; compiled first.
package bsc_pkg;

    localparam int ADC_W   = 24;
    localparam int COEF_W  = 16;
    localparam int OUT_W   = 23;
    localparam int DT_W    = 25;
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int OFF_W   = 35;
    localparam int SENS_W  = 34;
    localparam int ACC_W   = 60;
    localparam int SENS_SPLIT = 17;

    localparam int COEF_COUNT = 6;
    localparam int CFG_IDX_W  = $clog2(COEF_COUNT);

    localparam int STEP_W = 4;

    localparam logic signed [PROD_W-1:0] TEMP_BASE = PROD_W'(2000);

    // Coefficient register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS        = 3'd0,
        REG_OFFSET      = 3'd1,
        REG_SENS_TEMP   = 3'd2,
        REG_OFFSET_TEMP = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5
    } cfg_reg_t;

    // Reading kinds
    typedef enum logic {
        KIND_TEMP  = 1'b0,
        KIND_PRESS = 1'b1
    } kind_t;

    typedef enum logic {
        A_DT  = 1'b0,
        A_ADC = 1'b1
    } mul_a_t;

    typedef enum logic [2:0] {
        B_SLOPE   = 3'd0,
        B_OTC     = 3'd1,
        B_STC     = 3'd2,
        B_SENS_LO = 3'd3,
        B_SENS_HI = 3'd4
    } mul_b_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_TEMP   = 3'd1,
        OP_OFF    = 3'd2,
        OP_SENS   = 3'd3,
        OP_LOAD   = 3'd4,
        OP_ADD_HI = 3'd5,
        OP_PRESS  = 3'd6
    } dp_op_t;

    typedef struct packed {
        logic              jump_press;
        logic [STEP_W-1:0] target;
        logic              dt_load;
        logic              mul_en;
        mul_a_t            a_sel;
        mul_b_t            b_sel;
        dp_op_t            op;
        logic              last;
    } ctrl_t;

    localparam logic [STEP_W-1:0] PRESS_ENTRY = STEP_W'(4);

    // Microcode ROM. Temperature: steps 0-3. Pressure: steps 0, 4-10.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{jump_press: 1'b0, target: '0, dt_load: 1'b0, mul_en: 1'b0,
              a_sel: A_DT, b_sel: B_SLOPE, op: OP_NONE, last: 1'b0};
        case (step)
            4'd0:
            begin
                c.jump_press = 1'b1;
                c.target     = PRESS_ENTRY;
            end
            4'd1: c.dt_load = 1'b1;
            4'd2:
            begin
                c.mul_en = 1'b1;
                c.b_sel  = B_SLOPE;
            end
            4'd3:
            begin
                c.op   = OP_TEMP;
                c.last = 1'b1;
            end
            4'd4:
            begin
                c.mul_en = 1'b1;
                c.b_sel  = B_OTC;
            end
            4'd5:
            begin
                c.op     = OP_OFF;
                c.mul_en = 1'b1;
                c.b_sel  = B_STC;
            end
            4'd6: c.op = OP_SENS;
            4'd7:
            begin
                c.mul_en = 1'b1;
                c.a_sel  = A_ADC;
                c.b_sel  = B_SENS_LO;
            end
            4'd8:
            begin
                c.op     = OP_LOAD;
                c.mul_en = 1'b1;
                c.a_sel  = A_ADC;
                c.b_sel  = B_SENS_HI;
            end
            4'd9: c.op = OP_ADD_HI;
            4'd10:
            begin
                c.op   = OP_PRESS;
                c.last = 1'b1;
            end
            default: c.last = 1'b1;
        endcase
        return c;
    endfunction

endpackage

@@ src/bsc_req_if.sv @@
// Request channel: raw converter reading tagged with its kind.
// Depends on bsc_pkg.
interface bsc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [bsc_pkg::ADC_W-1:0] adc_value;

    modport source (output valid, output req_type, output adc_value, input ready);
    modport sink   (input valid, input req_type, input adc_value, output ready);
endinterface

@@ src/bsc_res_if.sv @@
// Result channel: compensated temperature or pressure.
// Depends on bsc_pkg.
interface bsc_res_if;
    logic                             valid;
    logic                             ready;
    logic                             value_kind;
    logic signed [bsc_pkg::OUT_W-1:0] comp_value;

    modport source (output valid, output value_kind, output comp_value, input ready);
    modport sink   (input valid, input value_kind, input comp_value, output ready);
endinterface

@@ src/barometric_sensor_compensation_unit.sv @@
// Barometric sensor first-order compensation, microcoded over one shared
// 25x18 signed multiplier. Depends on bsc_pkg, bsc_req_if, bsc_res_if.
// A temperature request walks microcode steps 0-3, a pressure request steps 0
// and 4-10; the last step waits for the output register. ready is low while a
// request is in progress, so a new reading is taken only after the last result.
// Reset (rst_n, async low): idle, output empty, coefficients and dT cleared.
module barometric_sensor_compensation_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    bsc_req_if.sink                       req,
    bsc_res_if.source                     res,
    input  logic                          cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsc_pkg::COEF_W-1:0]    cfg_wdata
);
    import bsc_pkg::*;

    // ---------------------------------------------------------------
    // Coefficient registers
    // ---------------------------------------------------------------
    logic [COEF_W-1:0] coef_reg [COEF_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_COUNT; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(COEF_COUNT)))
        begin
            coef_reg[cfg_index] <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: step counter walking the microcode ROM
    // ---------------------------------------------------------------
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              kind_reg;
    logic [ADC_W-1:0]  adc_reg;
    ctrl_t             ctrl;
    logic              in_xfer;
    logic              out_free;
    logic              finish;

    logic                     res_valid_reg, res_valid_next;
    logic                     res_kind_reg;
    logic signed [OUT_W-1:0]  res_value_reg;
    logic signed [OUT_W-1:0]  result;

    assign ctrl      = ucode(step_reg);
    assign req.ready = !busy_reg;
    assign in_xfer   = req.valid && req.ready;
    // Output register can take a new result if empty or being drained now.
    assign out_free  = !res_valid_reg || res.ready;
    // The last step stalls until the output register frees up.
    assign finish    = busy_reg && ctrl.last && out_free;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (in_xfer)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (ctrl.last)
            begin
                if (out_free)
                begin
                    busy_next = 1'b0;
                end
            end
            else if (ctrl.jump_press && (kind_reg == KIND_PRESS))
            begin
                step_next = ctrl.target;
            end
            else
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg <= req.req_type;
            adc_reg  <= req.adc_value;
        end
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    logic signed [DT_W-1:0]    dt_reg;
    logic signed [DT_W-1:0]    dt_next;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [OFF_W-1:0]   off_reg;
    logic signed [SENS_W-1:0]  sens_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic signed [PROD_W-1:0]  prod_sh7;
    logic signed [PROD_W-1:0]  prod_sh8;
    logic signed [PROD_W-1:0]  temp_sum;
    logic signed [ACC_W-1:0]   press_diff;
    logic signed [ACC_W-1:0]   press_sh;

    // dT = adc - ref * 256, always fits 25 signed bits
    assign dt_next = $signed({1'b0, adc_reg})
                   - $signed({1'b0, coef_reg[REG_REF_TEMP], 8'h00});

    always_comb
    begin
        case (ctrl.a_sel)
            A_DT:    mul_a = dt_reg;
            A_ADC:   mul_a = $signed({1'b0, adc_reg});
            default: mul_a = dt_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.b_sel)
            B_SLOPE:   mul_b = $signed({2'b00, coef_reg[REG_TEMP_SLOPE]});
            B_OTC:     mul_b = $signed({2'b00, coef_reg[REG_OFFSET_TEMP]});
            B_STC:     mul_b = $signed({2'b00, coef_reg[REG_SENS_TEMP]});
            // SENS split: unsigned low 17 bits, signed high 17 bits
            B_SENS_LO: mul_b = $signed({1'b0, sens_reg[SENS_SPLIT-1:0]});
            B_SENS_HI: mul_b = $signed({sens_reg[SENS_W-1], sens_reg[SENS_W-1:SENS_SPLIT]});
            default:   mul_b = '0;
        endcase
    end

    assign prod_sh7 = prod_reg >>> 7;
    assign prod_sh8 = prod_reg >>> 8;
    assign temp_sum = (prod_reg >>> 23) + TEMP_BASE;

    // P = ((adc * SENS) >> 21 - OFF) >> 15
    assign press_diff = (acc_reg >>> 21) - ACC_W'(off_reg);
    assign press_sh   = press_diff >>> 15;

    always_comb
    begin
        case (ctrl.op)
            OP_TEMP:  result = temp_sum[OUT_W-1:0];
            OP_PRESS: result = press_sh[OUT_W-1:0];
            default:  result = temp_sum[OUT_W-1:0];
        endcase
    end

    // dT (dt_reg) is architectural state; reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= '0;
        end
        else if (busy_reg && ctrl.dt_load)
        begin
            dt_reg <= dt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (ctrl.mul_en)
            begin
                prod_reg <= mul_a * mul_b;
            end
            case (ctrl.op)
                OP_OFF:
                begin
                    off_reg <= $signed({3'b000, coef_reg[REG_OFFSET], 16'h0000})
                             + prod_sh7[OFF_W-1:0];
                end
                OP_SENS:
                begin
                    sens_reg <= $signed({3'b000, coef_reg[REG_SENS], 15'h0000})
                              + prod_sh8[SENS_W-1:0];
                end
                OP_LOAD:   acc_reg <= ACC_W'(prod_reg);
                OP_ADD_HI: acc_reg <= acc_reg + $signed({prod_reg, 17'h00000});
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            res_kind_reg  <= kind_reg;
            res_value_reg <= result;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.value_kind = res_kind_reg;
    assign res.comp_value = res_value_reg;

endmodule

@@ dv/tb.sv @@
// Self-checking bench for barometric_sensor_compensation_unit: random and directed
// readings, coefficient loads, and a scoreboard that predicts each compensated value.
// Depends on bsc_pkg, bsc_req_if, bsc_res_if and the unit itself.

import bsc_pkg::*;

typedef logic [COEF_W-1:0] coeff_set_t [COEF_COUNT];

// One compensated value still owed by the unit
typedef struct {
    logic             kind;
    logic [OUT_W-1:0] value;
} owed_value_t;

class compensation_sb;
    localparam longint ZERO_TEMP   = 2000;  // 20.00 C at the reference point
    localparam int     REF_SHIFT   = 8;
    localparam int     SLOPE_SHIFT = 23;
    localparam int     OFF_SHIFT   = 16;
    localparam int     OTC_SHIFT   = 7;
    localparam int     SENS_SHIFT  = 15;
    localparam int     STC_SHIFT   = 8;
    localparam int     SCALE_SHIFT = 21;
    localparam int     PRESS_SHIFT = 15;

    logic [COEF_W-1:0] coeff [COEF_COUNT];
    longint            temp_diff;
    owed_value_t       owed [$];
    int unsigned       errors;

    function new();
        foreach (coeff[i])
            coeff[i] = '0;
        temp_diff = 0;
        errors    = 0;
    endfunction

    function void set_coeff(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        if (idx < COEF_COUNT)
            coeff[idx] = data;
    endfunction

    // Accepted reading: work out the compensated value it must produce
    function void note_reading(input kind_t kind, input logic [ADC_W-1:0] adc);
        longint      raw;
        longint      off;
        longint      sens;
        longint      val;
        owed_value_t item;
        raw = longint'(adc);
        if (kind == KIND_TEMP)
        begin
            temp_diff = raw - (longint'(coeff[REG_REF_TEMP]) << REF_SHIFT);
            val = ZERO_TEMP + ((temp_diff * longint'(coeff[REG_TEMP_SLOPE])) >>> SLOPE_SHIFT);
        end
        else
        begin
            off  = (longint'(coeff[REG_OFFSET]) << OFF_SHIFT)
                 + ((temp_diff * longint'(coeff[REG_OFFSET_TEMP])) >>> OTC_SHIFT);
            sens = (longint'(coeff[REG_SENS]) << SENS_SHIFT)
                 + ((temp_diff * longint'(coeff[REG_SENS_TEMP])) >>> STC_SHIFT);
            val  = (((raw * sens) >>> SCALE_SHIFT) - off) >>> PRESS_SHIFT;
        end
        item.kind  = kind;
        item.value = val[OUT_W-1:0];
        owed.push_back(item);
    endfunction

    function void check_result(input logic kind, input logic [OUT_W-1:0] value);
        owed_value_t item;
        if (owed.size() == 0)
        begin
            $error("unexpected result: value_kind %0d comp_value %0d", kind, $signed(value));
            errors++;
            return;
        end
        item = owed.pop_front();
        if (kind !== item.kind)
        begin
            $error("value_kind: expected %0d, actual %0d", item.kind, kind);
            errors++;
        end
        if (value !== item.value)
        begin
            $error("comp_value: expected %0d, actual %0d", $signed(item.value), $signed(value));
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int     RESET_CYCLES = 7;
    localparam int     SETTLE_GAP   = 12;     // settle time in drain() after the last result
    localparam int     HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam longint RUN_LIMIT    = 2_000_000;

    // Realistic factory calibration, in register order
    localparam coeff_set_t TYPICAL_COEFFS = '{16'd40127, 16'd36924, 16'd23317,
                                              16'd23282, 16'd33464, 16'd28312};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_wdata;

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    bit          hold_pending;

    compensation_sb sb = new();

    bsc_req_if req ();
    bsc_res_if res ();

    barometric_sensor_compensation_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Hard stop in case a transfer never happens
    initial
    begin
        #RUN_LIMIT;
        $display("tb failed");
        $finish;
    end

    // Transfer monitor. Runs right after the edge, so it sees the values the
    // unit sampled. Results are checked before the new reading is noted; a
    // result in this edge always belongs to an older reading.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
                sb.check_result(res.value_kind, res.comp_value);
            if (req.valid && req.ready)
                sb.note_reading(kind_t'(req.req_type), req.adc_value);
        end
    end

    // Result-side backpressure. A hold-off request parks ready low for a fixed
    // count of cycles, counted here, while the sender keeps offering.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Random gap, then offer one reading and hold it until transferred.
    // valid stays high on return so back-to-back readings never glitch it.
    task automatic send_reading(input kind_t kind, input logic [ADC_W-1:0] adc);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= kind;
        req.adc_value <= adc;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every owed value is back, then let the
    // sequencer settle before anything touches the coefficients.
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // Write all six coefficients back to back, then one write to a spare
    // index, which the unit must drop. Only called while the unit is idle.
    task automatic load_coeffs(input coeff_set_t vals);
        logic [CFG_IDX_W-1:0] spare;
        logic [COEF_W-1:0]    junk;
        for (int i = 0; i < COEF_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.set_coeff(CFG_IDX_W'(i), vals[i]);
        end
        spare = CFG_IDX_W'(COEF_COUNT + $urandom_range(1));
        junk  = COEF_W'($urandom);
        cfg_index <= spare;
        cfg_wdata <= junk;
        @(posedge clk);
        sb.set_coeff(spare, junk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] pick_coeff();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return COEF_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic coeff_set_t pick_coeff_set();
        coeff_set_t vals;
        case ($urandom_range(4))
            0:       vals = TYPICAL_COEFFS;
            1:       foreach (vals[i]) vals[i] = '1;
            default: foreach (vals[i]) vals[i] = pick_coeff();
        endcase
        return vals;
    endfunction

    // Mostly full-range readings, with the rails and readings just above the
    // reference temperature (small or zero difference) mixed in.
    function automatic logic [ADC_W-1:0] pick_adc();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return {sb.coeff[REG_REF_TEMP], 8'($urandom_range(255))};
            default: return ADC_W'($urandom);
        endcase
    endfunction

    // Well-formed traffic is a temperature reading followed by a few pressure
    // readings; the rest is readings of random kind in any order.
    task automatic run_readings(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                send_reading(KIND_TEMP, pick_adc());
                burst = $urandom_range(4, 1);
                repeat (burst) send_reading(KIND_PRESS, pick_adc());
                sent += burst + 1;
            end
            else
            begin
                send_reading(kind_t'($urandom_range(1)), pick_adc());
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (2)
        begin
            load_coeffs(pick_coeff_set());
            run_readings(200);
            drain();
        end
    endtask

    initial
    begin
        coeff_set_t all_max;
        coeff_set_t all_zero;

        foreach (all_max[i])
        begin
            all_max[i]  = '1;
            all_zero[i] = '0;
        end

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        req.valid     = 1'b0;
        req.req_type  = KIND_TEMP;
        req.adc_value = '0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_pending  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: realistic calibration. Pressure comes first, so it must
        // use the reset difference (the reference temperature).
        load_coeffs(TYPICAL_COEFFS);
        send_reading(KIND_PRESS, 24'h5A3C00);
        send_reading(KIND_PRESS, '1);
        send_reading(KIND_PRESS, '0);
        send_reading(KIND_TEMP, {TYPICAL_COEFFS[REG_REF_TEMP], 8'h00});  // zero difference
        send_reading(KIND_PRESS, 24'h8A0000);
        send_reading(KIND_TEMP, '0);
        send_reading(KIND_PRESS, '1);
        send_reading(KIND_TEMP, '1);
        send_reading(KIND_PRESS, '1);
        send_reading(KIND_PRESS, '0);
        drain();

        // Directed: every coefficient at its maximum, both difference extremes
        load_coeffs(all_max);
        send_reading(KIND_TEMP, '0);      // most negative difference
        send_reading(KIND_PRESS, '1);
        send_reading(KIND_PRESS, '0);
        send_reading(KIND_TEMP, '1);
        send_reading(KIND_PRESS, '1);
        send_reading(KIND_PRESS, 24'h800000);
        drain();

        // Directed: all coefficients zero
        load_coeffs(all_zero);
        send_reading(KIND_TEMP, '1);
        send_reading(KIND_PRESS, '1);
        send_reading(KIND_TEMP, '0);
        send_reading(KIND_PRESS, '0);
        drain();

        // Random: sender-side gaps, heavy receiver stalls; then swapped
        run_phase(30, 81);
        run_phase(81, 30);

        // No idling. Start with a long receiver hold-off while readings keep
        // coming, so the unit backs up and stalls its request side.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        load_coeffs(pick_coeff_set());
        hold_pending = 1'b1;
        run_readings(40);
        drain();
        load_coeffs(pick_coeff_set());
        run_readings(160);
        drain();
        load_coeffs(pick_coeff_set());
        run_readings(200);
        drain();

        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
